// ===== design/button_debounce_press_classifier_assert.svh =====
// Assertion macros used by the top-level design file.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside reset.
`define BDPC_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("bdpc assertion failed");
// Same check with a caller-supplied message.
`define BDPC_ASSERT_MSG(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error(msg);
`else
`define BDPC_ASSERT(lbl, clk_s, rst_s, prop)
`define BDPC_ASSERT_MSG(lbl, clk_s, rst_s, prop, msg)
`endif

`endif

// ===== design/bdpc_pkg.sv =====
`default_nettype none

package bdpc_pkg;

  // Width of the tick counters; they saturate at all ones.
  localparam int COUNT_WIDTH = 16;
  // Width of the configuration registers.
  localparam int CFG_WIDTH   = 16;
  // Common width used to compare a counter against a register.
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int INDEX_WIDTH = 8;

  // Register indexes.
  localparam logic [INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS   = INDEX_WIDTH'(0);
  localparam logic [INDEX_WIDTH-1:0] REG_LONG_PRESS_TICKS = INDEX_WIDTH'(1);

  // Reset values of the registers.
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(50);
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(1000);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // One result item.
  typedef struct packed {
    logic held;
    logic long_press;
    logic short_press;
  } result_t;

  // Configuration write request.
  typedef struct packed {
    logic                   we;
    logic [INDEX_WIDTH-1:0] index;
    logic [CFG_WIDTH-1:0]   data;
  } cfg_wr_t;

  // Saturating increment.
  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == '1) ? v : v + COUNT_WIDTH'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/bdpc_core.sv =====
`default_nettype none

// Debounce and press classification state; one sample per step.
module bdpc_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bdpc_pkg::cfg_wr_t cfg,
  input  wire logic              step,
  input  wire logic              raw_level,
  output bdpc_pkg::result_t      result
);

  logic [bdpc_pkg::CFG_WIDTH-1:0] debounce_ticks;
  logic [bdpc_pkg::CFG_WIDTH-1:0] long_press_ticks;

  logic             last_raw;
  logic             stable_level;
  bdpc_pkg::count_t since_change;
  bdpc_pkg::count_t hold_count;
  logic             long_fired;

  logic             last_raw_next;
  logic             stable_level_next;
  bdpc_pkg::count_t since_change_next;
  bdpc_pkg::count_t hold_count_next;
  logic             long_fired_next;
  logic             accept_level;
  logic             long_hit;

  // Compute the state after this sample and the result it yields.
  always_comb begin
    result = '0;
    hold_count_next = (stable_level == 1'b0) ? bdpc_pkg::sat_inc(hold_count) : hold_count;
    if (raw_level != last_raw) begin
      last_raw_next     = raw_level;
      since_change_next = '0;
    end else begin
      last_raw_next     = last_raw;
      since_change_next = bdpc_pkg::sat_inc(since_change);
    end
    stable_level_next = stable_level;
    long_fired_next   = long_fired;
    accept_level = (bdpc_pkg::CMP_WIDTH'(since_change_next) >=
                    bdpc_pkg::CMP_WIDTH'(debounce_ticks)) && (raw_level != stable_level);
    if (accept_level) begin
      stable_level_next = raw_level;
      if (stable_level) begin
        hold_count_next = '0;
        long_fired_next = 1'b0;
      end else begin
        result.short_press = !long_fired;
      end
    end
    long_hit = !stable_level_next && !long_fired_next &&
               (bdpc_pkg::CMP_WIDTH'(hold_count_next) >=
                bdpc_pkg::CMP_WIDTH'(long_press_ticks));
    result.long_press = long_hit;
    long_fired_next   = long_fired_next | long_hit;
    result.held       = !stable_level_next;
  end

  // Hold configuration and advance state on each accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bdpc_pkg::DEBOUNCE_RESET;
      long_press_ticks <= bdpc_pkg::LONG_PRESS_RESET;
      last_raw         <= 1'b1;
      stable_level     <= 1'b1;
      since_change     <= '0;
      hold_count       <= '0;
      long_fired       <= 1'b0;
    end else begin
      if (cfg.we) begin
        if (cfg.index == bdpc_pkg::REG_DEBOUNCE_TICKS) begin
          debounce_ticks <= cfg.data;
        end else if (cfg.index == bdpc_pkg::REG_LONG_PRESS_TICKS) begin
          long_press_ticks <= cfg.data;
        end
      end
      if (step) begin
        last_raw     <= last_raw_next;
        stable_level <= stable_level_next;
        since_change <= since_change_next;
        hold_count   <= hold_count_next;
        long_fired   <= long_fired_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/button_debounce_press_classifier.sv =====
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    s_tdata[0] raw_level
// m_axis    out  m_tvalid/m_tready    m_tdata[0] short, [1] long, [2] held
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (16 bit)
//
// One sample per cycle unless m_tready stalls; its result shows in the next cycle.
// The state update is a single pass of counter and compare logic feeding
// the output register; s_tready is high whenever that register is empty or
// being drained, so a stalled m_tready stalls input one-for-one.
// Synchronous reset restores both registers and the released-button state.
`default_nettype none

`include "button_debounce_press_classifier_assert.svh"

module button_debounce_press_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  input  wire logic [7:0]                         s_tdata,   // [0] raw_level
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  output      logic [7:0]                         m_tdata,   // [0] short_press,
                                                             // [1] long_press, [2] held
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [bdpc_pkg::INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [bdpc_pkg::CFG_WIDTH-1:0]     cfg_data
);

  bdpc_pkg::cfg_wr_t cfg;
  bdpc_pkg::result_t result;
  bdpc_pkg::result_t out_reg;
  logic              step;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  bdpc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .raw_level (s_tdata[0]),
    .result    (result)
  );

  // Load the output register on each transaction, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {5'b0, out_reg.held, out_reg.long_press, out_reg.short_press};

  `BDPC_ASSERT(a_press_exclusive, clk, rst, !(m_tvalid && m_tdata[0] && m_tdata[1]))
  `BDPC_ASSERT(a_short_released, clk, rst, (m_tvalid && m_tdata[0]) |-> !m_tdata[2])
  `BDPC_ASSERT_MSG(a_long_held, clk, rst, (m_tvalid && m_tdata[1]) |-> m_tdata[2], "long, not held")
  `BDPC_ASSERT_MSG(a_result_follows, clk, rst, (s_tvalid && s_tready) |=> m_tvalid, "no result")

endmodule

`default_nettype wire
